// ===== rtl/rsdat_pkg.sv =====
// Shared types, codes and constants for the stream deframer and ack tracker.
// Used by every module of the block; depends on nothing.
package rsdat_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [31:0] MAX_UNACKED_RST = 32'd65536;
    localparam logic [31:0] AUTO_ACK_RST    = 32'd10240;

    // Highest legal size code in a header nibble.
    localparam logic [3:0] MAX_SIZE_CODE = 4'd4;

    // Configuration register indexes.
    localparam logic CFG_MAX_UNACKED = 1'b0;
    localparam logic CFG_AUTO_ACK    = 1'b1;

    // Send verdict codes.
    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_REFUSE = 2'd1;

    typedef enum logic [2:0] {
        EV_DATA    = 3'd0,
        EV_VERDICT = 3'd1,
        EV_ACKREQ  = 3'd2,
        EV_HDRERR  = 3'd3,
        EV_SEND    = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REPEAT  = 2'd1,
        ST_SMALLER = 2'd2,
        ST_SHORT   = 2'd3
    } t_ack_st;

    typedef enum logic [1:0] {
        OP_DATA = 2'd0,
        OP_DONE = 2'd1,
        OP_SEND = 2'd2,
        OP_HERR = 2'd3
    } t_op;

    // Command passed from the parser to the accounting side.
    typedef struct packed {
        t_op         op;
        logic [7:0]  data;
        logic [63:0] ack;
        logic [31:0] len;
        logic        ack_chk;
        logic        rx_upd;
    } t_cmd;

    // Field size in bytes for a legal size code.
    function automatic logic [3:0] code_bytes(input logic [2:0] code);
        logic [3:0] n;
        case (code)
            3'd0:    n = 4'd0;
            3'd1:    n = 4'd1;
            3'd2:    n = 4'd2;
            3'd3:    n = 4'd4;
            3'd4:    n = 4'd8;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/rsdat_front.sv =====
// Packet parser: classifies each accepted word and issues commands.
// Depends on rsdat_pkg.
module rsdat_front import rsdat_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_kind,
    input  logic [7:0]  i_link_byte,
    input  logic [31:0] i_send_len,
    output logic        o_push,
    output t_cmd        o_cmd
);

    typedef enum logic [1:0] {
        PH_HDR = 2'd0,
        PH_ACK = 2'd1,
        PH_LEN = 2'd2,
        PH_PAY = 2'd3
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_ack_code, n_ack_code;
    logic [2:0]  r_len_code, n_len_code;
    logic [2:0]  r_idx, n_idx;
    logic [63:0] r_ack, n_ack;
    logic [31:0] r_plen, n_plen;
    logic [31:0] r_prem, n_prem;

    logic [3:0]  w_ac, w_lc;
    logic [2:0]  w_idx_inc;
    logic [63:0] w_ack_or;
    logic [31:0] w_len_or;
    logic [31:0] w_prem_dec;

    always_comb begin
        n_phase    = r_phase;
        n_ack_code = r_ack_code;
        n_len_code = r_len_code;
        n_idx      = r_idx;
        n_ack      = r_ack;
        n_plen     = r_plen;
        n_prem     = r_prem;
        o_push     = 1'b0;
        o_cmd      = '0;
        w_ac       = i_link_byte[3:0];
        w_lc       = i_link_byte[7:4];
        w_idx_inc  = r_idx + 3'd1;
        w_ack_or   = r_ack | ({56'd0, i_link_byte} << {r_idx, 3'b000});
        w_len_or   = r_plen;
        if (!r_idx[2]) begin
            w_len_or = r_plen | ({24'd0, i_link_byte} << {r_idx[1:0], 3'b000});
        end
        w_prem_dec = (r_prem != 32'd0) ? r_prem - 32'd1 : r_prem;

        if (i_accept) begin
            if (i_kind) begin
                o_push    = 1'b1;
                o_cmd.op  = OP_SEND;
                o_cmd.len = i_send_len;
            end else begin
                unique case (r_phase)
                    PH_HDR: begin
                        if (w_ac > MAX_SIZE_CODE || w_lc > MAX_SIZE_CODE) begin
                            o_push   = 1'b1;
                            o_cmd.op = OP_HERR;
                        end else begin
                            n_ack_code = w_ac[2:0];
                            n_len_code = w_lc[2:0];
                            n_ack      = '0;
                            n_plen     = '0;
                            n_prem     = '0;
                            n_idx      = '0;
                            if (code_bytes(w_ac[2:0]) != 4'd0) begin
                                n_phase = PH_ACK;
                            end else if (code_bytes(w_lc[2:0]) != 4'd0) begin
                                n_phase = PH_LEN;
                            end else begin
                                n_phase = PH_HDR;
                            end
                        end
                    end
                    PH_ACK: begin
                        n_ack = w_ack_or;
                        n_idx = w_idx_inc;
                        if (w_idx_inc == 3'd0 ||
                            {1'b0, w_idx_inc} >= code_bytes(r_ack_code)) begin
                            n_idx = '0;
                            if (code_bytes(r_len_code) != 4'd0) begin
                                n_phase = PH_LEN;
                            end else begin
                                n_phase = PH_HDR;
                                if (w_ack_or != 64'd0) begin
                                    o_push        = 1'b1;
                                    o_cmd.op      = OP_DONE;
                                    o_cmd.ack     = w_ack_or;
                                    o_cmd.ack_chk = 1'b1;
                                end
                            end
                        end
                    end
                    PH_LEN: begin
                        n_plen = w_len_or;
                        n_idx  = w_idx_inc;
                        if (w_idx_inc == 3'd0 ||
                            {1'b0, w_idx_inc} >= code_bytes(r_len_code)) begin
                            n_idx = '0;
                            if (w_len_or != 32'd0) begin
                                n_prem  = w_len_or;
                                n_phase = PH_PAY;
                            end else begin
                                n_phase = PH_HDR;
                                if (r_ack != 64'd0) begin
                                    o_push        = 1'b1;
                                    o_cmd.op      = OP_DONE;
                                    o_cmd.ack     = r_ack;
                                    o_cmd.ack_chk = 1'b1;
                                end
                            end
                        end
                    end
                    PH_PAY: begin
                        o_push     = 1'b1;
                        o_cmd.op   = OP_DATA;
                        o_cmd.data = i_link_byte;
                        n_prem     = w_prem_dec;
                        if (w_prem_dec == 32'd0) begin
                            // Last payload byte closes the packet.
                            o_cmd.ack     = r_ack;
                            o_cmd.ack_chk = (r_ack != 64'd0);
                            o_cmd.len     = r_plen;
                            o_cmd.rx_upd  = (r_plen != 32'd0);
                            n_phase       = PH_HDR;
                            n_idx         = '0;
                        end
                    end
                    default: begin
                        n_phase = PH_HDR;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR;
            r_ack_code <= '0;
            r_len_code <= '0;
            r_idx      <= '0;
            r_ack      <= '0;
            r_plen     <= '0;
            r_prem     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_ack_code <= n_ack_code;
            r_len_code <= n_len_code;
            r_idx      <= n_idx;
            r_ack      <= n_ack;
            r_plen     <= n_plen;
            r_prem     <= n_prem;
        end
    end

endmodule

// ===== rtl/rsdat_fifo.sv =====
// Short command queue between the parser and the accounting side.
// Depends on rsdat_pkg for the command type.
module rsdat_fifo import rsdat_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty,
    output logic o_full
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/rsdat_back.sv =====
// Ack, receive and send accounting with the registered result stage.
// Depends on rsdat_pkg; takes commands from rsdat_fifo.
module rsdat_back import rsdat_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_head_vld,
    input  t_cmd        i_head,
    output logic        o_pop,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_data_byte,
    output logic [63:0] o_offset,
    output logic [1:0]  o_status,
    output logic        o_last
);

    logic [31:0] r_max_unacked, r_auto_thr;
    logic [63:0] r_remote, r_rx_off, r_req_off;
    logic [31:0] r_unacked, r_auto_cnt;
    logic        r_busy, r_rem_verd, r_rem_req;
    t_ack_st     r_vst;

    logic        r_ovld, r_last;
    t_event      r_ev;
    logic [7:0]  r_byte;
    logic [63:0] r_off;
    logic [1:0]  r_st;

    logic [63:0] c_delta, c_rx_off;
    t_ack_st     c_vst;
    logic [32:0] c_cnt_sum, c_snd_sum;
    logic [31:0] c_cnt_sat;
    logic        c_pkt, c_req, c_refuse;

    logic        w_load, w_fire, w_last;
    t_event      w_ev;
    logic [7:0]  w_byte;
    logic [63:0] w_off;
    logic [1:0]  w_st;

    // Ack verdict against the remote offset and the unacked window.
    always_comb begin
        c_delta = i_head.ack - r_remote;
        if (r_remote == i_head.ack) begin
            c_vst = ST_REPEAT;
        end else if (r_remote > i_head.ack) begin
            c_vst = ST_SMALLER;
        end else if ((|c_delta[63:32]) || (c_delta[31:0] > r_unacked)) begin
            c_vst = ST_SHORT;
        end else begin
            c_vst = ST_OK;
        end
    end

    assign c_pkt     = (i_head.op == OP_DATA) || (i_head.op == OP_DONE);
    assign c_cnt_sum = {1'b0, r_auto_cnt} + {1'b0, i_head.len};
    assign c_cnt_sat = c_cnt_sum[32] ? '1 : c_cnt_sum[31:0];
    assign c_rx_off  = r_rx_off + {32'd0, i_head.len};
    assign c_req     = c_pkt && i_head.rx_upd && (c_cnt_sat >= r_auto_thr);
    assign c_snd_sum = {1'b0, r_unacked} + {1'b0, i_head.len};
    assign c_refuse  = c_snd_sum >= {1'b0, r_max_unacked};

    assign w_load = !r_ovld || !i_out_stall;
    assign w_fire = i_head_vld && w_load;
    assign o_pop  = w_fire && w_last;

    always_comb begin
        w_ev   = EV_DATA;
        w_byte = '0;
        w_off  = '0;
        w_st   = '0;
        w_last = 1'b1;
        if (r_busy) begin
            if (r_rem_verd) begin
                w_ev   = EV_VERDICT;
                w_off  = i_head.ack;
                w_st   = r_vst;
                w_last = !r_rem_req;
            end else begin
                w_ev  = EV_ACKREQ;
                w_off = r_req_off;
            end
        end else begin
            unique case (i_head.op)
                OP_DATA: begin
                    w_ev   = EV_DATA;
                    w_byte = i_head.data;
                    w_last = !(i_head.ack_chk || c_req);
                end
                OP_DONE: begin
                    w_ev   = EV_VERDICT;
                    w_off  = i_head.ack;
                    w_st   = c_vst;
                    w_last = !c_req;
                end
                OP_SEND: begin
                    w_ev = EV_SEND;
                    w_st = c_refuse ? ST_REFUSE : ST_ACCEPT;
                end
                OP_HERR: begin
                    w_ev = EV_HDRERR;
                end
                default: begin
                    w_ev = EV_HDRERR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_unacked <= MAX_UNACKED_RST;
            r_auto_thr    <= AUTO_ACK_RST;
            r_remote      <= '0;
            r_rx_off      <= '0;
            r_req_off     <= '0;
            r_unacked     <= '0;
            r_auto_cnt    <= '0;
            r_busy        <= 1'b0;
            r_rem_verd    <= 1'b0;
            r_rem_req     <= 1'b0;
            r_vst         <= ST_OK;
            r_ovld        <= 1'b0;
            r_ev          <= EV_DATA;
            r_byte        <= '0;
            r_off         <= '0;
            r_st          <= '0;
            r_last        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MAX_UNACKED) begin
                    r_max_unacked <= i_cfg_data;
                end else if (i_cfg_idx == CFG_AUTO_ACK) begin
                    r_auto_thr <= i_cfg_data;
                end
            end

            if (w_load) begin
                r_ovld <= w_fire;
            end
            if (w_fire) begin
                r_ev   <= w_ev;
                r_byte <= w_byte;
                r_off  <= w_off;
                r_st   <= w_st;
                r_last <= w_last;

                if (r_busy) begin
                    r_rem_verd <= 1'b0;
                    if (w_last) begin
                        r_busy <= 1'b0;
                    end
                end else begin
                    // All state changes of a command happen on its first word.
                    if (i_head.op == OP_SEND && !c_refuse) begin
                        r_unacked <= c_snd_sum[31:0];
                    end
                    if (c_pkt && i_head.ack_chk && c_vst == ST_OK) begin
                        r_unacked <= r_unacked - c_delta[31:0];
                        r_remote  <= i_head.ack;
                    end
                    if (c_pkt && i_head.rx_upd) begin
                        r_rx_off   <= c_rx_off;
                        r_auto_cnt <= c_req ? '0 : c_cnt_sat;
                    end
                    r_busy     <= !w_last;
                    r_rem_verd <= (i_head.op == OP_DATA) && i_head.ack_chk;
                    r_rem_req  <= c_req;
                    r_vst      <= c_vst;
                    r_req_off  <= c_rx_off;
                end
            end
        end
    end

    assign o_out_valid = r_ovld;
    assign o_event_res = r_ev;
    assign o_data_byte = r_byte;
    assign o_offset    = r_off;
    assign o_status    = r_st;
    assign o_last      = r_last;

endmodule

// ===== rtl/reliable_stream_deframer_ack_tracker_top.sv =====
// Each item passes the command queue and then the registered result stage.
// One input word per cycle while the queue has room and each item yields at most one result
// word; an item that yields more (up to three at a packet's end) holds the accounting side.
// A command queue of QUEUE_DEPTH entries lets the parser keep accepting meanwhile.
// Reset is synchronous and active low: the parser expects a header, the queue is empty, all
// counters are zero and the registers return to 65536 and 10240. No clearing pass follows.
module reliable_stream_deframer_ack_tracker_top import rsdat_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_link_byte,
    input  logic [31:0] i_send_len,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_data_byte,
    output logic [63:0] o_offset,
    output logic [1:0]  o_status,
    output logic        o_last,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    // The front parser sees every accepted word. Words that only advance the parse
    // (header and field bytes) produce no command; everything else is turned into a
    // command and queued. The input stalls only when the queue is full, so a waiting
    // result word never blocks the link by itself.
    logic w_accept;
    logic w_push;
    t_cmd w_cmd;
    t_cmd w_head;
    logic w_empty;
    logic w_full;
    logic w_pop;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    rsdat_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_kind      (i_kind),
        .i_link_byte (i_link_byte),
        .i_send_len  (i_send_len),
        .o_push      (w_push),
        .o_cmd       (w_cmd)
    );

    rsdat_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // The back side works through the queue in order. It commits all state changes of
    // a command on that command's first result word and replays any remaining words
    // (ack verdict, then ack request) as later result words. The output register
    // loads whenever it is empty or its word is being taken.
    rsdat_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_head_vld  (!w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_event_res (o_event_res),
        .o_data_byte (o_data_byte),
        .o_offset    (o_offset),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

// ===== rtl/rsdat_checker.sv =====
// Port-level checks for the deframer top level, attached by the bind below.
// Depends on rsdat_pkg for the event codes.
module rsdat_checker import rsdat_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_event_res,
    input logic [7:0]  o_data_byte,
    input logic [63:0] o_offset,
    input logic [1:0]  o_status,
    input logic        o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_event_res) && $stable(o_offset) && $stable(o_last))
        else $error("result word changed while stalled");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res == EV_ACKREQ || o_event_res == EV_SEND ||
                        o_event_res == EV_HDRERR) |-> o_last && o_data_byte == 8'd0)
        else $error("closing event without last mark");

    a_followup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=>
            o_out_valid && (o_event_res == EV_VERDICT || o_event_res == EV_ACKREQ))
        else $error("packet end words not delivered back to back");

endmodule

bind reliable_stream_deframer_ack_tracker_top rsdat_checker u_rsdat_checker (.*);
